/* hw/rtl/dfam_pkg.sv */
// ----------------------------------------------------------------------------
// DFA minimizer package
// Field widths and fixed constants shared by the minimizer RTL.
// ----------------------------------------------------------------------------
package dfam_pkg;

   // Width of a state index field on the request and response channels.
   localparam int FIELD_W = 4;

   // Width of the state count register and its reset value.
   localparam int COUNT_W = 5;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // Number of states that a field of FIELD_W bits can name.
   localparam int FIELD_STATES = 16;

   typedef logic [FIELD_W-1:0] state_idx_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

/* hw/rtl/dfa_state_minimizer.sv */
// ----------------------------------------------------------------------------
// DFA state minimizer
// Loads a two-symbol DFA row by row and reduces it by Moore partition
// refinement, then reports the representative of every state.
//
// Usage: a row is transferred at a clock edge with start high and busy low.
// Rows without req_last_row are stored and busy stays low.
// A row with req_last_row is stored and starts minimization over the first
// N states (N is csr state count, clamped to 1..min(MAX_STATES,16)); busy
// stays high during the run and goes low as the last result appears.
// Phases, all inside one class memory with a single read port:
//   initial split       states split into accepting and rejecting classes
//   each round          signatures for every state, then the lowest-match
//                       search for each state
//   rounds              at most N+1, fewer when no class splits
//   output              one result per state
// Results come out in state order, each on the rsp_ ports for one cycle
// with rsp_valid high; the receiver cannot stall them.
// Reset clears the control logic and sets the state count to 16; the row
// memory is not cleared; the class memory needs none, as every run rewrites it.
// ----------------------------------------------------------------------------
module dfa_state_minimizer #(
   parameter int MAX_STATES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dfam_pkg::state_idx_type req_row_state,
   input  dfam_pkg::state_idx_type req_next_on_a,
   input  dfam_pkg::state_idx_type req_next_on_b,
   input  logic                   req_accepting,
   input  logic                   req_last_row,
   output logic                   rsp_valid,
   output dfam_pkg::state_idx_type rsp_out_state,
   output dfam_pkg::state_idx_type rsp_representative,
   output logic                   rsp_last_result,
   input  logic                   csr_wr_en,
   input  dfam_pkg::count_type    csr_wr_data
);

   localparam int DEPTH = (MAX_STATES < dfam_pkg::FIELD_STATES) ?
                          MAX_STATES : dfam_pkg::FIELD_STATES;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int CW    = dfam_pkg::COUNT_W;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      idx_type    own;
      logic       a_none;
      idx_type    a_cls;
      logic       b_none;
      idx_type    b_cls;
   } sig_type;

   typedef struct packed {
      dfam_pkg::state_idx_type succ_a;
      dfam_pkg::state_idx_type succ_b;
      logic                    final_flag;
   } row_type;

   typedef struct packed {
      logic [1:0][IDX_W-1:0] cls;
      sig_type               sig;
   } cls_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_RD,
      ST_INIT_WR,
      ST_SIG_RD,
      ST_SIG_A,
      ST_SIG_B,
      ST_SIG_WR,
      ST_SCAN_RD,
      ST_SCAN_GET,
      ST_SCAN_CMP,
      ST_ROUND_END,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } fsm_type;

   // Memories and their registered read data.
   row_type       row_mem [DEPTH];
   cls_entry_type cls_mem [DEPTH];
   row_type       row_q_ff;
   cls_entry_type cls_q_ff;

   logic          row_we;
   idx_type       row_waddr;
   row_type       row_wdata;
   idx_type       row_raddr;
   logic          cls_we;
   logic          cls_wbank;
   idx_type       cls_waddr;
   idx_type       cls_wdata;
   logic          sig_we;
   sig_type       sig_wdata;
   idx_type       cls_raddr;

   // Control and registered outputs.
   fsm_type       state_ff, state_in;
   dfam_pkg::count_type count_ff, count_in;
   cnt_type       n_ff, n_in;
   idx_type       i_ff, i_in;
   idx_type       j_ff, j_in;
   cnt_type       round_ff, round_in;
   logic          bank_ff, bank_in;
   logic          split_ff, split_in;
   logic          acc_seen_ff, acc_seen_in;
   idx_type       acc_first_ff, acc_first_in;
   logic          rej_seen_ff, rej_seen_in;
   idx_type       rej_first_ff, rej_first_in;
   idx_type       own_ff, own_in;
   logic          a_none_ff, a_none_in;
   idx_type       a_cls_ff, a_cls_in;
   dfam_pkg::state_idx_type succ_b_ff, succ_b_in;
   sig_type       sig_i_ff, sig_i_in;
   logic          rsp_valid_ff, rsp_valid_in;
   idx_type       rsp_state_ff, rsp_state_in;
   idx_type       rsp_rep_ff, rsp_rep_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          i_is_last;
   logic          b_none;
   dfam_pkg::count_type clamped_count;

   assign accept    = start && (state_ff == ST_IDLE);
   assign i_is_last = ({1'b0, i_ff} == (n_ff - cnt_type'(1)));
   assign b_none    = !({1'b0, succ_b_ff} < CW'(n_ff));

   always_comb begin
      clamped_count = count_ff;
      if (count_ff == '0) begin
         clamped_count = CW'(1);
      end else if (count_ff > CW'(DEPTH)) begin
         clamped_count = CW'(DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_q_ff <= row_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (cls_we) begin
         cls_mem[cls_waddr].cls[cls_wbank] <= cls_wdata;
      end
      if (sig_we) begin
         cls_mem[cls_waddr].sig <= sig_wdata;
      end
      cls_q_ff <= cls_mem[cls_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      round_in     = round_ff;
      bank_in      = bank_ff;
      split_in     = split_ff;
      acc_seen_in  = acc_seen_ff;
      acc_first_in = acc_first_ff;
      rej_seen_in  = rej_seen_ff;
      rej_first_in = rej_first_ff;
      own_in       = own_ff;
      a_none_in    = a_none_ff;
      a_cls_in     = a_cls_ff;
      succ_b_in    = succ_b_ff;
      sig_i_in     = sig_i_ff;
      rsp_valid_in = 1'b0;
      rsp_state_in = rsp_state_ff;
      rsp_rep_in   = rsp_rep_ff;
      rsp_last_in  = rsp_last_ff;

      row_we    = 1'b0;
      row_waddr = req_row_state[IDX_W-1:0];
      row_wdata = '{succ_a: req_next_on_a, succ_b: req_next_on_b,
                    final_flag: req_accepting};
      row_raddr = i_ff;
      cls_we    = 1'b0;
      cls_wbank = bank_ff;
      cls_waddr = i_ff;
      cls_wdata = i_ff;
      sig_we    = 1'b0;
      sig_wdata = sig_i_ff;
      cls_raddr = i_ff;

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_we = ({1'b0, req_row_state} < CW'(DEPTH));
               if (req_last_row) begin
                  n_in        = cnt_type'(clamped_count);
                  i_in        = '0;
                  round_in    = '0;
                  bank_in     = 1'b0;
                  acc_seen_in = 1'b0;
                  rej_seen_in = 1'b0;
                  state_in    = ST_INIT_RD;
               end
            end
         end
         ST_INIT_RD: begin
            state_in = ST_INIT_WR;
         end
         ST_INIT_WR: begin
            // A class is named by its lowest state, so the first accepting
            // and first rejecting states seen name the two initial classes.
            cls_we = 1'b1;
            if (row_q_ff.final_flag) begin
               if (acc_seen_ff) begin
                  cls_wdata = acc_first_ff;
               end else begin
                  acc_seen_in  = 1'b1;
                  acc_first_in = i_ff;
               end
            end else begin
               if (rej_seen_ff) begin
                  cls_wdata = rej_first_ff;
               end else begin
                  rej_seen_in  = 1'b1;
                  rej_first_in = i_ff;
               end
            end
            if (i_is_last) begin
               i_in     = '0;
               state_in = ST_SIG_RD;
            end else begin
               i_in     = i_ff + idx_type'(1);
               state_in = ST_INIT_RD;
            end
         end
         ST_SIG_RD: begin
            state_in = ST_SIG_A;
         end
         ST_SIG_A: begin
            own_in    = cls_q_ff.cls[bank_ff];
            succ_b_in = row_q_ff.succ_b;
            a_none_in = !({1'b0, row_q_ff.succ_a} < CW'(n_ff));
            cls_raddr = row_q_ff.succ_a[IDX_W-1:0];
            state_in  = ST_SIG_B;
         end
         ST_SIG_B: begin
            a_cls_in  = a_none_ff ? '0 : cls_q_ff.cls[bank_ff];
            cls_raddr = succ_b_ff[IDX_W-1:0];
            state_in  = ST_SIG_WR;
         end
         ST_SIG_WR: begin
            sig_we    = 1'b1;
            sig_wdata = '{own: own_ff, a_none: a_none_ff, a_cls: a_cls_ff,
                          b_none: b_none,
                          b_cls: b_none ? '0 : cls_q_ff.cls[bank_ff]};
            if (i_is_last) begin
               i_in     = '0;
               split_in = 1'b0;
               state_in = ST_SCAN_RD;
            end else begin
               i_in     = i_ff + idx_type'(1);
               state_in = ST_SIG_RD;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_GET;
         end
         ST_SCAN_GET: begin
            sig_i_in  = cls_q_ff.sig;
            j_in      = '0;
            cls_raddr = '0;
            state_in  = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            // The read for the next candidate is issued while this one is
            // compared; the search always ends by j equal to i.
            cls_raddr = j_ff + idx_type'(1);
            j_in      = j_ff + idx_type'(1);
            if (cls_q_ff.sig == sig_i_ff) begin
               cls_we    = 1'b1;
               cls_wbank = !bank_ff;
               cls_wdata = j_ff;
               if (j_ff != sig_i_ff.own) begin
                  split_in = 1'b1;
               end
               if (i_is_last) begin
                  state_in = ST_ROUND_END;
               end else begin
                  i_in     = i_ff + idx_type'(1);
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_ROUND_END: begin
            bank_in  = !bank_ff;
            round_in = round_ff + cnt_type'(1);
            i_in     = '0;
            if (!split_ff || (round_ff == n_ff)) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_SIG_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_state_in = i_ff;
            rsp_rep_in   = cls_q_ff.cls[bank_ff];
            rsp_last_in  = i_is_last;
            if (i_is_last) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + idx_type'(1);
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= dfam_pkg::COUNT_RESET;
         n_ff         <= cnt_type'(1);
         round_ff     <= '0;
         bank_ff      <= 1'b0;
         split_ff     <= 1'b0;
         acc_seen_ff  <= 1'b0;
         rej_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         round_ff     <= round_in;
         bank_ff      <= bank_in;
         split_ff     <= split_in;
         acc_seen_ff  <= acc_seen_in;
         rej_seen_ff  <= rej_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      acc_first_ff <= acc_first_in;
      rej_first_ff <= rej_first_in;
      own_ff       <= own_in;
      a_none_ff    <= a_none_in;
      a_cls_ff     <= a_cls_in;
      succ_b_ff    <= succ_b_in;
      sig_i_ff     <= sig_i_in;
      rsp_state_ff <= rsp_state_in;
      rsp_rep_ff   <= rsp_rep_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_state      = dfam_pkg::FIELD_W'(rsp_state_ff);
   assign rsp_representative = dfam_pkg::FIELD_W'(rsp_rep_ff);
   assign rsp_last_result    = rsp_last_ff;

   // A representative is the lowest state of its class.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_representative <= rsp_out_state))
      else $error("representative above its own state");

   // Only the final result may appear once the block has gone idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_result) |-> busy)
      else $error("result outside a run");

   // A final row always starts a run.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_row) |=> busy)
      else $error("final row did not start minimization");

   // The final result closes the run; no result follows it directly.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |=> !rsp_valid)
      else $error("activity after final result");

endmodule
